[rtl/dfd_pkg.sv]
// Package for the datagram frame deframer: phase type, result record,
// status and kind codes, and buffer size constant. No dependencies.
package dfd_pkg;

	localparam int unsigned MaxBufferBytes = 65535;
	localparam logic [7:0] TypeNoLen = 8'h30;
	localparam int unsigned VarintW = 62;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_RAW,
		PH_VFIRST,
		PH_VMORE,
		PH_PAYLOAD,
		PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_TRUNC_LEN = 2'd1,
		ST_SHORT     = 2'd2
	} status_t;

	localparam logic KindPayload = 1'b0;
	localparam logic KindStatus  = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [7:0]  payload_byte;
		logic        payload_last;
		logic [1:0]  status;
		logic [15:0] consumed;
		logic        has_length;
		logic        allowed;
	} result_t;

endpackage

[rtl/datagram_frame_deframer.sv]
// Datagram frame deframer top level: parses one frame buffer a byte per
// transfer and emits payload bytes and a closing status. Uses dfd_pkg.
//
// Channel  Dir  Handshake          Payload
// s_       in   s_tvalid/s_tready  s_tdata = data_in, s_tlast = buffer_end
// m_       out  m_tvalid/m_tready  m_tuser = kind, m_tlast = payload_last, m_tdata
// cfg_     in   cfg_we             cfg_wdata = max_frame_size
//
// One input byte is parsed in the cycle it is taken and its results are written
// to a four-entry result queue, so a byte is accepted every cycle while the
// queue has room for two results. A byte that closes a buffer with payload
// yields two results, a payload byte and a status. Reset clears the parser and
// the queue at once; a stall on the output side fills the queue and then holds
// s_tready low.
module datagram_frame_deframer #(
	parameter int unsigned MAX_BUFFER_BYTES = dfd_pkg::MaxBufferBytes
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] data_in
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] payload_byte, [9:8] status, [25:10] consumed, [26] has_length,
	// [27] allowed, [31:28] zero
	output logic [31:0] m_tdata,
	output logic        m_tuser,  // [0] kind
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);
	import dfd_pkg::*;

	localparam logic [15:0] SatCount = 16'(MAX_BUFFER_BYTES);
	localparam logic [VarintW-1:0] RemOne = VarintW'(1);

	logic [15:0]        max_frame_size_q;
	phase_t             phase_q, phase_d;
	logic [2:0]         len_left_q, len_left_d;
	logic [VarintW-1:0] remain_q, remain_d;
	logic [15:0]        byte_cnt_q, byte_cnt_d;
	logic               len_field_q, len_field_d;

	result_t            res_q [4];
	logic [1:0]         wptr_q, rptr_q;
	logic [2:0]         cnt_q;

	logic               in_xfer, out_xfer;
	result_t            res0, res1;
	logic [1:0]         push_n;
	logic [VarintW-1:0] rem_dec;
	logic [VarintW-1:0] rem_shift;
	logic [1:0]         wptr_p1;

	assign in_xfer  = s_tvalid & s_tready;
	assign out_xfer = m_tvalid & m_tready;
	assign s_tready = cnt_q <= 3'd2;
	assign m_tvalid = cnt_q != 3'd0;
	assign rem_dec   = remain_q - RemOne;
	assign rem_shift = {remain_q[VarintW-9:0], s_tdata};
	assign wptr_p1   = wptr_q + 2'd1;

	always_comb begin
		phase_d     = phase_q;
		len_left_d  = len_left_q;
		remain_d    = remain_q;
		len_field_d = len_field_q;
		byte_cnt_d  = byte_cnt_q;
		if (phase_q != PH_DONE && byte_cnt_q < SatCount) begin
			byte_cnt_d = byte_cnt_q + 16'd1;
		end
		unique case (phase_q)
			PH_IDLE: begin
				len_field_d = s_tdata != TypeNoLen;
				phase_d     = (s_tdata != TypeNoLen) ? PH_VFIRST : PH_RAW;
			end
			PH_RAW: begin
			end
			PH_VFIRST: begin
				len_left_d = 3'((4'd1 << s_tdata[7:6]) - 4'd1);
				remain_d   = VarintW'(s_tdata[5:0]);
				if (s_tdata[7:6] != 2'd0) begin
					phase_d = PH_VMORE;
				end else begin
					phase_d = (s_tdata[5:0] != 6'd0) ? PH_PAYLOAD : PH_DONE;
				end
			end
			PH_VMORE: begin
				remain_d   = rem_shift;
				len_left_d = len_left_q - 3'd1;
				if (len_left_q == 3'd1) begin
					phase_d = (rem_shift != '0) ? PH_PAYLOAD : PH_DONE;
				end
			end
			PH_PAYLOAD: begin
				remain_d = rem_dec;
				if (rem_dec == '0) begin
					phase_d = PH_DONE;
				end
			end
			default: begin
				phase_d = PH_DONE;
			end
		endcase
	end

	always_comb begin
		logic    pay;
		result_t stat;
		pay  = (phase_q == PH_RAW) || (phase_q == PH_PAYLOAD);
		res0 = '0;
		res1 = '0;
		stat = '0;
		stat.kind       = KindStatus;
		stat.has_length = len_field_d;
		if (phase_d == PH_VFIRST || phase_d == PH_VMORE) begin
			stat.status = ST_TRUNC_LEN;
		end else if (phase_d == PH_PAYLOAD) begin
			stat.status = ST_SHORT;
		end else begin
			stat.status   = ST_OK;
			stat.consumed = byte_cnt_d;
			stat.allowed  = (max_frame_size_q != 16'd0) && (byte_cnt_d <= max_frame_size_q);
		end
		if (pay) begin
			res0.kind         = KindPayload;
			res0.payload_byte = s_tdata;
			res0.payload_last = s_tlast | ((phase_q == PH_PAYLOAD) && (rem_dec == '0));
			res1              = stat;
			push_n            = s_tlast ? 2'd2 : 2'd1;
		end else begin
			res0   = stat;
			push_n = s_tlast ? 2'd1 : 2'd0;
		end
		if (!in_xfer) begin
			push_n = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_frame_size_q <= '0;
			phase_q          <= PH_IDLE;
			len_left_q       <= '0;
			remain_q         <= '0;
			byte_cnt_q       <= '0;
			len_field_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_frame_size_q <= cfg_wdata;
			end
			if (in_xfer) begin
				if (s_tlast) begin
					phase_q     <= PH_IDLE;
					len_left_q  <= '0;
					remain_q    <= '0;
					byte_cnt_q  <= '0;
					len_field_q <= 1'b0;
				end else begin
					phase_q     <= phase_d;
					len_left_q  <= len_left_d;
					remain_q    <= remain_d;
					byte_cnt_q  <= byte_cnt_d;
					len_field_q <= len_field_d;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			wptr_q <= wptr_q + push_n;
			if (out_xfer) begin
				rptr_q <= rptr_q + 2'd1;
			end
			cnt_q <= cnt_q + {1'b0, push_n} - {2'b00, out_xfer};
		end
	end

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			res_q[wptr_q] <= res0;
		end
		if (push_n == 2'd2) begin
			res_q[wptr_p1] <= res1;
		end
	end

	always_comb begin
		result_t head;
		head    = res_q[rptr_q];
		m_tuser = head.kind;
		m_tlast = head.payload_last;
		m_tdata = {4'd0, head.allowed, head.has_length, head.consumed,
			head.status, head.payload_byte};
	end

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'd4)
		else $error("result queue count out of range");

	a_end_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && s_tlast |=> phase_q == PH_IDLE && byte_cnt_q == 16'd0)
		else $error("parser not cleared after buffer end");

	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> byte_cnt_q == 16'd0 && !len_field_q)
		else $error("idle parser holds frame state");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KindStatus && m_tdata[9:8] != ST_OK
		|-> m_tdata[25:10] == 16'd0 && !m_tdata[27])
		else $error("error status reports consumed bytes");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push_n != 2'd0 |-> cnt_q + {1'b0, push_n} <= 3'd4 + {2'b00, out_xfer})
		else $error("result queue overflow");

endmodule
